FILE: src/pat_pkg.sv
// Shared types, constants and helpers of the paged address translator.
`default_nettype none
package pat_pkg;

	localparam int NUM_FRAMES_DEF        = 16;
	localparam int PAGES_PER_PROCESS_DEF = 1024;
	localparam int NUM_PROCESSES_DEF     = 4;
	localparam int PAGE_OFFSET_BITS_DEF  = 12;

	localparam int LA_W    = 22;
	localparam int PA_W    = 16;
	localparam int PID_W   = 3;
	localparam int CFG_W   = 5;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;

	localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_UNKNOWN  = 2'd1;
	localparam status_t STATUS_NOVICTIM = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_LOOKUP,
		ST_CHECK,
		ST_SCAN,
		ST_EVICT,
		ST_FILL,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic start;
		logic en;
	} scan_ctl_t;

	// Frame number shifted above the page offset, keeping the low output bits.
	function automatic logic [PA_W-1:0] phys_addr(input logic [31:0] frame,
		input logic [31:0] offset, input int unsigned offset_bits);
		logic [31:0] t;
		t = (frame << offset_bits) | offset;
		return t[PA_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: src/pat_table_ram.sv
// Page table memory: one write port, one registered read port.
`default_nettype none
module pat_table_ram
	import pat_pkg::*;
#(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 37
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: src/pat_lru_scan.sv
// Stamp comparator that tracks the oldest valid page during a scan.
`default_nettype none
module pat_lru_scan
	import pat_pkg::*;
#(
	parameter int PAGE_W  = 10,
	parameter int FRAME_W = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire scan_ctl_t          ctl,
	input  wire logic               ent_valid,
	input  wire logic [FRAME_W-1:0] ent_frame,
	input  wire logic [STAMP_W-1:0] ent_stamp,
	input  wire logic [PAGE_W-1:0]  ent_page,
	output logic                    found,
	output logic [PAGE_W-1:0]       best_page,
	output logic [FRAME_W-1:0]      best_frame
);

	logic [STAMP_W-1:0] oldest_q;
	logic               take;

	// Strict less-than keeps the first page on a tie.
	assign take = ctl.en && ent_valid && (!found || (ent_stamp < oldest_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (ctl.start) begin
			found <= 1'b0;
		end else if (take) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			oldest_q   <= ent_stamp;
			best_page  <= ent_page;
			best_frame <= ent_frame;
		end
	end

endmodule
`default_nettype wire

FILE: src/paged_address_translator_lru_unit.sv
// Top level of the paged address translator with LRU page replacement.
//
// An input beat carries a process id and a logical byte address; each one
// yields exactly one output beat with the physical address, the hit flag,
// a status code and the running hit and fault totals. The configuration
// channel sets the number of frames that may be handed out; cfg_ready is
// always high. Both data channels use valid/ready.
// A fault that must evict scans every page entry of the process through
// the single table read port, one entry per cycle. When PAGES_PER_PROCESS
// is not a power of two the page number is first reduced one address bit
// per cycle. One item is in work at a time; in_ready is high only while
// idle. After reset a clearing pass writes every table entry invalid, one
// per cycle; the table holds NUM_PROCESSES rounded up to a power of two
// times PAGES_PER_PROCESS rounded the same way entries (4096 by default),
// and no input beat is taken meanwhile. A finished beat waits in the
// output register while the receiver stalls and the block may already
// accept the next input beat.
`default_nettype none
module paged_address_translator_lru_unit
	import pat_pkg::*;
#(
	parameter int NUM_FRAMES        = NUM_FRAMES_DEF,
	parameter int PAGES_PER_PROCESS = PAGES_PER_PROCESS_DEF,
	parameter int NUM_PROCESSES     = NUM_PROCESSES_DEF,
	parameter int PAGE_OFFSET_BITS  = PAGE_OFFSET_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [PID_W-1:0] process_id,
	input  wire logic [LA_W-1:0]  logical_address,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [PA_W-1:0]       physical_address,
	output logic                  was_hit,
	output status_t               status,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int FRAME_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int PAGE_W    = $clog2(PAGES_PER_PROCESS);
	localparam int PIDX_W    = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int IDX_W     = PIDX_W + PAGE_W;
	localparam int VPN_W     = LA_W - PAGE_OFFSET_BITS;
	localparam int ENT_W     = 1 + FRAME_W + STAMP_W;
	localparam int MODC_W    = $clog2(VPN_W + 1);
	localparam bit PAGE_POW2 = ((1 << PAGE_W) == PAGES_PER_PROCESS);
	localparam logic [PAGE_W:0] PPP_C = (PAGE_W+1)'(PAGES_PER_PROCESS);
	localparam logic [MODC_W-1:0] VPN_C = MODC_W'(VPN_W);

	state_t state_q, state_d;

	logic [CFG_W-1:0]            frames_q;
	logic [NUM_FRAMES-1:0]       free_q;
	logic [STAMP_W-1:0]          clock_q;
	logic [CNT_W-1:0]            hit_q, miss_q;
	logic [IDX_W-1:0]            clr_q;
	logic [PIDX_W-1:0]           pid_q;
	logic [PAGE_W-1:0]           page_q;
	logic [PAGE_OFFSET_BITS-1:0] off_q;
	logic [VPN_W-1:0]            vpn_q;
	logic [MODC_W-1:0]           mod_cnt_q;
	logic [PAGE_W:0]             scan_cnt_q;
	logic                        rd_vld_s1;
	logic [PAGE_W-1:0]           rd_page_s1;
	logic [PA_W-1:0]             res_pa_q;
	logic                        res_hit_q;
	status_t                     res_st_q;

	logic [31:0]       vpn_ext;
	logic              in_acc, pid_known, out_load;
	logic [IDX_W-1:0]  idx;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr, mem_raddr;
	logic [ENT_W-1:0]  mem_wdata, mem_rdata;
	logic              r_valid;
	logic [FRAME_W-1:0] r_frame;
	logic [STAMP_W-1:0] r_stamp;
	logic              free_found;
	logic [FRAME_W-1:0] free_sel;
	logic              scan_iss;
	logic [PAGE_W:0]   mod_t, mod_r;
	scan_ctl_t         scan_ctl;
	logic              v_found;
	logic [PAGE_W-1:0] v_page;
	logic [FRAME_W-1:0] v_frame;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign pid_known = (32'(process_id) < 32'(NUM_PROCESSES));
	assign vpn_ext   = 32'(logical_address[LA_W-1:PAGE_OFFSET_BITS]);
	assign idx       = {pid_q, page_q};
	assign {r_valid, r_frame, r_stamp} = mem_rdata;
	assign scan_iss  = (scan_cnt_q != PPP_C);
	assign out_load  = (state_q == ST_RESP) && (!out_valid || out_ready);

	// One bit of the page number folds into the remainder per cycle.
	assign mod_t = {page_q, vpn_q[VPN_W-1]};
	assign mod_r = (mod_t >= PPP_C) ? (mod_t - PPP_C) : mod_t;

	// Lowest free frame below the active frame count.
	always_comb begin
		free_found = 1'b0;
		free_sel   = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (free_q[i] && (i < int'(frames_q))) begin
				free_found = 1'b1;
				free_sel   = FRAME_W'(i);
			end
		end
	end

	pat_table_ram #(
		.ADDR_W(IDX_W),
		.DATA_W(ENT_W)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	pat_lru_scan #(
		.PAGE_W (PAGE_W),
		.FRAME_W(FRAME_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.ent_valid (r_valid),
		.ent_frame (r_frame),
		.ent_stamp (r_stamp),
		.ent_page  (rd_page_s1),
		.found     (v_found),
		.best_page (v_page),
		.best_frame(v_frame)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					if (!pid_known) state_d = ST_RESP;
					else if (PAGE_POW2) state_d = ST_LOOKUP;
					else state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == VPN_C - MODC_W'(1)) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: state_d = ST_CHECK;
			ST_CHECK: begin
				if (r_valid || free_found) state_d = ST_RESP;
				else state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!scan_iss && !rd_vld_s1) state_d = v_found ? ST_EVICT : ST_RESP;
			end
			ST_EVICT: state_d = ST_FILL;
			ST_FILL:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		in_ready       = 1'b0;
		mem_we         = 1'b0;
		mem_waddr      = idx;
		mem_wdata      = '0;
		mem_raddr      = idx;
		scan_ctl.start = 1'b0;
		scan_ctl.en    = rd_vld_s1;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: in_ready = 1'b1;
			ST_CHECK: begin
				if (r_valid) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, r_frame, clock_q};
				end else if (free_found) begin
					mem_we    = 1'b1;
					mem_wdata = {1'b1, free_sel, clock_q};
				end else begin
					scan_ctl.start = 1'b1;
				end
			end
			ST_SCAN: mem_raddr = {pid_q, scan_cnt_q[PAGE_W-1:0]};
			ST_EVICT: begin
				mem_we    = 1'b1;
				mem_waddr = {pid_q, v_page};
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = {1'b1, v_frame, clock_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			frames_q   <= FRAMES_RESET;
			free_q     <= '1;
			clock_q    <= '0;
			hit_q      <= '0;
			miss_q     <= '0;
			clr_q      <= '0;
			mod_cnt_q  <= '0;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) frames_q <= cfg_data;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (in_acc) mod_cnt_q <= '0;
			else if (state_q == ST_MOD) mod_cnt_q <= mod_cnt_q + MODC_W'(1);
			if (state_q == ST_LOOKUP) clock_q <= clock_q + STAMP_W'(1);
			if (state_q == ST_CHECK) begin
				if (r_valid) begin
					hit_q <= hit_q + CNT_W'(1);
				end else begin
					miss_q <= miss_q + CNT_W'(1);
					if (free_found) free_q[free_sel] <= 1'b0;
				end
			end
			if (state_q == ST_CHECK) scan_cnt_q <= '0;
			else if ((state_q == ST_SCAN) && scan_iss)
				scan_cnt_q <= scan_cnt_q + (PAGE_W+1)'(1);
			rd_vld_s1 <= (state_q == ST_SCAN) && scan_iss;
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// Item payload and result registers.
	always_ff @(posedge clk) begin
		rd_page_s1 <= scan_cnt_q[PAGE_W-1:0];
		if (in_acc) begin
			pid_q    <= PIDX_W'(process_id);
			off_q    <= logical_address[PAGE_OFFSET_BITS-1:0];
			vpn_q    <= logical_address[LA_W-1:PAGE_OFFSET_BITS];
			page_q   <= PAGE_POW2 ? vpn_ext[PAGE_W-1:0] : '0;
			res_pa_q  <= '0;
			res_hit_q <= 1'b0;
			res_st_q  <= STATUS_UNKNOWN;
		end
		if (state_q == ST_MOD) begin
			page_q <= mod_r[PAGE_W-1:0];
			vpn_q  <= {vpn_q[VPN_W-2:0], 1'b0};
		end
		if (state_q == ST_CHECK) begin
			res_st_q <= STATUS_OK;
			if (r_valid) begin
				res_hit_q <= 1'b1;
				res_pa_q  <= phys_addr(32'(r_frame), 32'(off_q), PAGE_OFFSET_BITS);
			end else if (free_found) begin
				res_pa_q <= phys_addr(32'(free_sel), 32'(off_q), PAGE_OFFSET_BITS);
			end
		end
		if ((state_q == ST_SCAN) && !scan_iss && !rd_vld_s1 && !v_found) begin
			res_st_q <= STATUS_NOVICTIM;
			res_pa_q <= '0;
		end
		if (state_q == ST_FILL) begin
			res_pa_q <= phys_addr(32'(v_frame), 32'(off_q), PAGE_OFFSET_BITS);
		end
		if (out_load) begin
			physical_address <= res_pa_q;
			was_hit          <= res_hit_q;
			status           <= res_st_q;
			hit_total        <= hit_q;
			miss_total       <= miss_q;
		end
	end

	// A frame once handed out never returns to the free pool.
	a_free_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((free_q & ~$past(free_q)) == '0))
		else $error("frame returned to free pool");

	// An accepted beat always takes the block out of the ready state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after accepting a beat");

	// The scan never walks past the pages of one process.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= PPP_C)
		else $error("scan counter out of range");

	// Outside the clearing pass, only the evict step writes a page other than the item's own.
	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q != ST_CLEAR) && (state_q != ST_EVICT)) |-> (mem_waddr == idx))
		else $error("table write to a foreign entry");

endmodule
`default_nettype wire

FILE: verif/pat_checker.sv
// Checker that predicts and compares every output beat of the translator.
module pat_checker
	import pat_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic [PID_W-1:0] process_id,
	input wire logic [LA_W-1:0]  logical_address,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PA_W-1:0]  physical_address,
	input wire logic             was_hit,
	input wire status_t          status,
	input wire logic [CNT_W-1:0] hit_total,
	input wire logic [CNT_W-1:0] miss_total,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready,
	input wire logic [CFG_W-1:0] cfg_data,
	output int                   errors,
	output int                   pending
);
	localparam int NPROC = NUM_PROCESSES_DEF;
	localparam int NPAGE = PAGES_PER_PROCESS_DEF;
	localparam int NFRM  = NUM_FRAMES_DEF;
	localparam int OFFB  = PAGE_OFFSET_BITS_DEF;

	typedef struct packed {
		logic [PA_W-1:0]  pa;
		logic             hit;
		status_t          st;
		logic [CNT_W-1:0] hits;
		logic [CNT_W-1:0] misses;
	} xlate_t;

	logic             map_ok [NPROC*NPAGE];
	logic [3:0]       map_frame [NPROC*NPAGE];
	logic [31:0]      map_stamp [NPROC*NPAGE];
	logic             frame_avail [NFRM];
	logic [31:0]      use_clock, hit_cnt, miss_cnt;
	logic [CFG_W-1:0] frame_limit;
	xlate_t           expected_xlates [$];

	function automatic xlate_t translate(input logic [PID_W-1:0] pid,
		input logic [LA_W-1:0] la);
		xlate_t r;
		int base, idx, lim, victim;
		logic [31:0] off, oldest;
		logic found;
		r = '0;
		off = 32'(la[OFFB-1:0]);
		if (int'(pid) >= NPROC) begin
			r.st = STATUS_UNKNOWN;
			r.hits = hit_cnt;
			r.misses = miss_cnt;
			return r;
		end
		base = int'(pid) * NPAGE;
		idx = base + int'((32'(la) >> OFFB) % NPAGE);
		use_clock++;
		r.st = STATUS_OK;
		if (map_ok[idx]) begin
			hit_cnt++;
			map_stamp[idx] = use_clock;
			r.pa = PA_W'((32'(map_frame[idx]) << OFFB) | off);
			r.hit = 1'b1;
		end else begin
			miss_cnt++;
			lim = (int'(frame_limit) > NFRM) ? NFRM : int'(frame_limit);
			found = 1'b0;
			for (int f = 0; f < lim; f++) begin
				if (!found && frame_avail[f]) begin
					found = 1'b1;
					frame_avail[f] = 1'b0;
					map_ok[idx] = 1'b1;
					map_frame[idx] = f[3:0];
					map_stamp[idx] = use_clock;
				end
			end
			if (!found) begin
				victim = 0;
				oldest = 0;
				for (int p = 0; p < NPAGE; p++) begin
					if (map_ok[base+p] && (!found || map_stamp[base+p] < oldest)) begin
						found = 1'b1;
						victim = base + p;
						oldest = map_stamp[base+p];
					end
				end
				if (found) begin
					map_ok[victim] = 1'b0;
					map_frame[idx] = map_frame[victim];
					map_ok[idx] = 1'b1;
					map_stamp[idx] = use_clock;
				end
			end
			if (found)
				r.pa = PA_W'((32'(map_frame[idx]) << OFFB) | off);
			else
				r.st = STATUS_NOVICTIM;
		end
		r.hits = hit_cnt;
		r.misses = miss_cnt;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < NPROC*NPAGE; i++) begin
			map_ok[i] = 1'b0;
			map_frame[i] = '0;
			map_stamp[i] = '0;
		end
		for (int f = 0; f < NFRM; f++) frame_avail[f] = 1'b1;
		use_clock = 0;
		hit_cnt = 0;
		miss_cnt = 0;
		frame_limit = FRAMES_RESET;
	end

	assign pending = expected_xlates.size();

	always @(posedge clk) begin
		xlate_t e;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) frame_limit <= cfg_data;
			if (in_valid && in_ready)
				expected_xlates.push_back(translate(process_id, logical_address));
			if (out_valid && out_ready) begin
				if (expected_xlates.size() == 0) begin
					$display("unexpected output beat at %0t", $realtime);
					errors++;
				end else begin
					e = expected_xlates.pop_front();
					if (physical_address !== e.pa)
						report_mismatch("physical_address", 32'(physical_address), 32'(e.pa));
					if (was_hit !== e.hit)
						report_mismatch("was_hit", 32'(was_hit), 32'(e.hit));
					if (status !== e.st)
						report_mismatch("status", 32'(status), 32'(e.st));
					if (hit_total !== e.hits) report_mismatch("hit_total", hit_total, e.hits);
					if (miss_total !== e.misses)
						report_mismatch("miss_total", miss_total, e.misses);
				end
			end
		end
	end
endmodule

FILE: verif/tb_paged_address_translator_lru_unit.sv
// Testbench top: stimulus, handshake pacing and the final verdict.
module tb_paged_address_translator_lru_unit;
	import pat_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [PID_W-1:0] process_id = '0;
	logic [LA_W-1:0]  logical_address = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [PA_W-1:0]  physical_address;
	logic             was_hit;
	status_t          status;
	logic [CNT_W-1:0] hit_total, miss_total;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	int               errors, pending;
	int               cycle_count = 0;
	logic             calm = 1'b0;

	// Generous cap: the clearing pass, about 1200 items that may each scan
	// a full 1024-entry process table, plus idle bursts on both sides.
	localparam int CYCLE_LIMIT = 4000000;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	paged_address_translator_lru_unit dut (.*);

	pat_checker checker_i (.*);

	// The timeout watchdog runs on its own and ends the run if exceeded.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// The receiver stalls in random bursts until the calm
	// part at the end, where it takes every beat at once.
	initial begin
		int stall;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 17);
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// One input beat; valid is raised and held with its payload until the
	// handshake edge. A random gap may precede it while not in the calm part.
	// Valid stays high after the handshake so that back-to-back beats need
	// only one update of it; a gap or a drain drops it.
	task automatic send_beat(input logic [PID_W-1:0] pid, input logic [LA_W-1:0] la);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		process_id <= pid;
		logical_address <= la;
		do @(posedge clk); while (!in_ready);
	endtask

	// Wait until every expected beat is out and let the block settle, so that
	// it is surely idle before a register write.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Random address biased to the 24 lowest pages so hits and evictions both occur.
	function automatic logic [LA_W-1:0] pick_addr();
		logic [LA_W-1:0] a;
		a = LA_W'($urandom);
		if ($urandom_range(0, 3) != 0)
			a[LA_W-1:12] = (LA_W-12)'($urandom_range(0, 23));
		return a;
	endfunction

	initial begin
		logic [CFG_W-1:0] frame_settings [5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: extreme addresses, a repeat hit, unknown processes,
		// and with no frames left a process with no page gives a no-victim fault.
		write_frames(5'd2);
		send_beat(3'd0, 22'h000000);
		send_beat(3'd0, 22'h000fff);
		send_beat(3'd3, 22'h3fffff);
		send_beat(3'd4, 22'h123456);
		send_beat(3'd7, 22'h3fffff);
		send_beat(3'd1, 22'h001abc);
		send_beat(3'd3, 22'h3ff000);
		send_beat(3'd0, 22'h2aa555);
		send_beat(3'd0, 22'h155aaa);
		send_beat(3'd0, 22'h000123);
		send_beat(3'd2, 22'h000001);
		send_beat(3'd3, 22'h3ffffe);
		// Page numbers cannot pass the table size: 22 - 12 address bits give exactly 1024 pages.
		send_beat(3'd0, 22'h3ff7ff);
		send_beat(3'd1, 22'h200000);

		// The sender holds off until all outstanding beats have come out.
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_frames(frame_settings[ph]);
			for (int i = 0; i < 240; i++) begin
				if (ph == 4 && i == 160) calm = 1'b1;
				send_beat($urandom_range(0, 9) == 0 ? 3'($urandom_range(4, 7))
					: 3'($urandom_range(0, 3)), pick_addr());
			end
		end

		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

FILE: paged_address_translator_lru_unit.f
src/pat_pkg.sv
src/pat_table_ram.sv
src/pat_lru_scan.sv
src/paged_address_translator_lru_unit.sv
verif/pat_checker.sv
verif/tb_paged_address_translator_lru_unit.sv
